// File: rtl/nca_pkg.sv
// shared constants and types for the nearest centroid assignment core
// no dependencies

package nca_pkg;

    localparam int MAX_CENTROIDS_DEF = 16;
    localparam int MAX_DIMS_DEF      = 16;
    localparam int COORD_BITS_DEF    = 16;

    localparam int CFG_W   = 5;
    localparam int IDX_W   = 4;
    localparam int ACC_W   = 37;
    localparam int OUT_W   = 36;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] OUT_MAX   = {1'b0, {OUT_W{1'b1}}};

    typedef struct packed {
        logic vld;
        logic tail;
        logic add_en;
    } t_unit_ctl;

endpackage

// File: rtl/nearest_centroid_assign_core.sv
// top level of the nearest centroid assignment core: sequencer, config and result register
// depends on nca_pkg, nca_store, nca_acc, nca_sqdiff

// A load transaction (mode 0) writes one centroid coordinate. A point
// transaction (mode 1) walks rows 0 to centroids_in_use-1 through one pipelined
// subtract-square-accumulate unit, one row per cycle, and ready is low until it is done,
// through the drain of that single unit and, on the final coordinate of a point, longer
// while an earlier result still waits. Each pass tracks the minimum as the rows are
// written back; the final coordinate of a point places the result in an output register
// that holds it until taken; a following transaction is accepted while it waits. Running
// distances are cleared through per-row valid bits, so no clearing pass is needed.

module nearest_centroid_assign_core
    import nca_pkg::*;
#(
    parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic [IDX_W-1:0]             i_centroid_index,
    input  logic [IDX_W-1:0]             i_dim_index,
    input  logic signed [COORD_BITS-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [IDX_W-1:0]             o_nearest_index,
    output logic [OUT_W-1:0]             o_min_distance
);

    localparam int RW    = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH = MAX_CENTROIDS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                       r_state;
    logic [CFG_W-1:0]             r_cfg;
    logic [RW-1:0]                r_row;
    logic [DW-1:0]                r_dim;
    logic                         r_dim_ok;
    logic                         r_last;
    logic signed [COORD_BITS-1:0] r_value;
    t_unit_ctl                    r_rd_ctl;
    logic [RW-1:0]                r_rd_row;
    logic [ACC_W-1:0]             r_best;
    logic [RW-1:0]                r_best_row;
    logic                         r_out_valid;
    logic [IDX_W-1:0]             r_out_index;
    logic [OUT_W-1:0]             r_out_dist;

    logic                         in_fire;
    logic                         row_ok;
    logic                         dim_ok;
    logic                         store_we;
    logic [AW-1:0]                store_waddr;
    logic [AW-1:0]                store_raddr;
    logic signed [COORD_BITS-1:0] store_rdata;
    logic [ACC_W-1:0]             acc_rdata;
    logic [RW-1:0]                last_row;
    logic                         issue_tail;
    logic                         finish_go;
    t_unit_ctl                    u_ctl;
    logic [RW-1:0]                u_row;
    logic [ACC_W-1:0]             u_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign row_ok     = 32'(i_centroid_index) < MAX_CENTROIDS;
    assign dim_ok     = 32'(i_dim_index) < MAX_DIMS;

    // active rows, register clamped to 1 .. MAX_CENTROIDS
    always_comb begin
        if (r_cfg == '0) begin
            last_row = '0;
        end else if (32'(r_cfg) > MAX_CENTROIDS) begin
            last_row = RW'(MAX_CENTROIDS - 1);
        end else begin
            last_row = RW'(32'(r_cfg) - 1);
        end
    end

    assign issue_tail  = (r_row == last_row);
    assign finish_go   = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign store_we    = in_fire && !i_mode && row_ok && dim_ok;
    assign store_waddr = AW'(32'(i_centroid_index) * MAX_DIMS + 32'(i_dim_index));
    assign store_raddr = AW'(32'(r_row) * MAX_DIMS + (r_dim_ok ? 32'(r_dim) : 0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_rd_ctl <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_ctl <= '0;
                    if (in_fire && i_mode) begin
                        r_row   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rd_ctl <= '{vld: 1'b1, tail: issue_tail, add_en: r_dim_ok};
                    if (issue_tail) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_rd_ctl <= '0;
                    if (u_ctl.vld && u_ctl.tail) begin
                        r_state <= r_last ? ST_FINISH : ST_IDLE;
                    end
                end
                ST_FINISH: begin
                    r_rd_ctl <= '0;
                    if (finish_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_rd_ctl <= '0;
                    r_state  <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= r_row;
        if (in_fire && i_mode) begin
            r_dim    <= DW'(i_dim_index);
            r_dim_ok <= dim_ok;
            r_last   <= i_last;
            r_value  <= i_value;
        end
        // first row seeds the minimum, strict compare keeps the lowest index on ties
        if (u_ctl.vld && (u_row == '0 || u_acc < r_best)) begin
            r_best     <= u_acc;
            r_best_row <= u_row;
        end
        if (finish_go) begin
            r_out_index <= IDX_W'(r_best_row);
            r_out_dist  <= (r_best > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : r_best[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    nca_store #(
        .DEPTH      (DEPTH),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (i_value),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    nca_acc #(
        .DEPTH (MAX_CENTROIDS),
        .RW    (RW)
    ) u_acc_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (finish_go),
        .i_we    (u_ctl.vld),
        .i_waddr (u_row),
        .i_wdata (u_acc),
        .i_raddr (r_row),
        .o_rdata (acc_rdata)
    );

    nca_sqdiff #(
        .COORD_BITS (COORD_BITS),
        .RW         (RW)
    ) u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_rd_ctl),
        .i_row      (r_rd_row),
        .i_centroid (store_rdata),
        .i_point    (r_value),
        .i_acc      (acc_rdata),
        .o_ctl      (u_ctl),
        .o_row      (u_row),
        .o_acc      (u_acc)
    );

    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_index;
    assign o_min_distance  = r_out_dist;

    a_busy_while_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_ctl.vld |-> !o_in_ready)
        else $error("transaction accepted while the unit is busy");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_row <= last_row))
        else $error("row counter beyond active rows");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_go |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result not posted after finish");

    a_tail_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_ctl.vld && u_ctl.tail) |-> (r_state == ST_DRAIN))
        else $error("last row written back outside drain");

endmodule

// File: rtl/nca_store.sv
// centroid coordinate memory, one write and one registered read port
// depends on nca_pkg

module nca_store
    import nca_pkg::*;
#(
    parameter int DEPTH      = MAX_CENTROIDS_DEF * MAX_DIMS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic signed [COORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic signed [COORD_BITS-1:0] o_rdata
);

    logic signed [COORD_BITS-1:0] r_mem [DEPTH];
    logic signed [COORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nca_acc.sv
// running distance memory with per-row valid bits; invalid rows read as zero
// depends on nca_pkg

module nca_acc
    import nca_pkg::*;
#(
    parameter int DEPTH = MAX_CENTROIDS_DEF,
    parameter int RW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_we,
    input  logic [RW-1:0]    i_waddr,
    input  logic [ACC_W-1:0] i_wdata,
    input  logic [RW-1:0]    i_raddr,
    output logic [ACC_W-1:0] o_rdata
);

    logic [ACC_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [ACC_W-1:0] r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[i_raddr];
        r_rvalid <= r_valid[i_raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// File: rtl/nca_sqdiff.sv
// shared subtract, square and saturating accumulate unit, three register stages
// depends on nca_pkg

module nca_sqdiff
    import nca_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int RW         = $clog2(MAX_CENTROIDS_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_unit_ctl                    i_ctl,
    input  logic [RW-1:0]                i_row,
    input  logic signed [COORD_BITS-1:0] i_centroid,
    input  logic signed [COORD_BITS-1:0] i_point,
    input  logic [ACC_W-1:0]             i_acc,
    output t_unit_ctl                    o_ctl,
    output logic [RW-1:0]                o_row,
    output logic [ACC_W-1:0]             o_acc
);

    localparam int MW = COORD_BITS + 1;
    localparam int SW = 2 * MW;

    logic signed [MW-1:0] diff;
    logic [MW-1:0]        mag;
    logic [SW-1:0]        sq;
    logic                 sq_big;
    logic [ACC_W:0]       sum;

    t_unit_ctl        r_ctl1, r_ctl2, r_ctl3;
    logic [RW-1:0]    r_row1, r_row2, r_row3;
    logic [ACC_W-1:0] r_acc1, r_acc2, r_acc3;
    logic [MW-1:0]    r_mag;
    logic [SW-1:0]    r_sq;

    assign diff = {i_centroid[COORD_BITS-1], i_centroid} - {i_point[COORD_BITS-1], i_point};
    assign mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
    assign sq   = r_mag * r_mag;

    // square is dropped when the dimension is out of range
    always_comb begin
        sq_big = r_ctl2.add_en && ((r_sq >> ACC_W) != '0);
        sum    = {1'b0, r_acc2} + (r_ctl2.add_en ? {1'b0, ACC_W'(r_sq)} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row1 <= i_row;
        r_acc1 <= i_acc;
        r_mag  <= mag;
        r_row2 <= r_row1;
        r_acc2 <= r_acc1;
        r_sq   <= sq;
        r_row3 <= r_row2;
        if (sq_big || sum >= {1'b0, ACC_MAX}) begin
            r_acc3 <= ACC_MAX;
        end else begin
            r_acc3 <= sum[ACC_W-1:0];
        end
    end

    assign o_ctl = r_ctl3;
    assign o_row = r_row3;
    assign o_acc = r_acc3;

endmodule
